>>> design/llu_pkg.sv
// Shared widths, constants, bus types and the arctangent table function.
`timescale 1ns / 1ps
package llu_pkg;

  // Field widths of one transaction.
  localparam int unsigned LAT_W = 24;
  localparam int unsigned LON_W = 25;
  localparam int unsigned OUT_W = 32;

  // Internal widths: angle in degrees (Q16), rotation vector (Q40), angle in radians (Q60).
  localparam int unsigned ANG_W = 25;
  localparam int unsigned XY_W  = 43;
  localparam int unsigned Z_W   = 63;

  localparam int unsigned CORDIC_STEPS = 40;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG180_U64 = 64'd11796480;

  // Degrees (Q16) to radians (Q60) scale factor, split into two partial products.
  localparam int unsigned DRAD_W    = 39;
  localparam int unsigned DRAD_LO_W = 20;
  localparam int unsigned DRAD_HI_W = DRAD_W - DRAD_LO_W;
  localparam logic [DRAD_W-1:0] DEG2RAD = DRAD_W'(PI_Q60 / DEG180_U64);

  // Product widths of the two partial products.
  localparam int unsigned PLO_W = ANG_W + DRAD_LO_W + 1;
  localparam int unsigned PHI_W = ANG_W + DRAD_HI_W + 1;

  localparam logic signed [ANG_W-1:0] DEG90  = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 25'sd11796480;

  // Start vector of the rotation: the inverse CORDIC gain in Q40.
  localparam logic [XY_W-1:0] GAIN_Q40 = 43'h09B74EDA843;

  localparam logic signed [OUT_W-1:0] ONE_Q30 = 32'sd1073741824;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
  } lane_t;

  typedef struct packed {
    logic  err;
    logic  neg;
    lane_t lat;
    lane_t lon;
  } cell_bus_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             err;
  } result_t;

  // atan(2^-idx) in Q60. Step zero is pi/4; the others sum the alternating series
  // term by term, each term found by a restoring long division at elaboration.
  function automatic logic [Z_W-1:0] atan_q60(int unsigned idx);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    int unsigned d;
    int unsigned e;
    int unsigned k;
    int          b;
    if (idx == 0) begin
      return Z_W'(PI_Q60 >> 2);
    end
    sum = '0;
    for (k = 0; k < 31; k++) begin
      d = 2 * k + 1;
      if (d * idx <= 60) begin
        e   = 60 - d * idx;
        num = 64'd1 << e;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= 64'(d)) begin
            rem    = rem - 64'(d);
            quo[b] = 1'b1;
          end
        end
        if (k[0]) begin
          sum = sum - quo;
        end else begin
          sum = sum + quo;
        end
      end
    end
    return Z_W'(sum);
  endfunction

endpackage

>>> design/llu_in_if.sv
// Input channel: one point as latitude and longitude in degrees.
`timescale 1ns / 1ps
interface llu_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [llu_pkg::LAT_W-1:0] lat_deg;
  logic signed [llu_pkg::LON_W-1:0] lon_deg;

  modport source (output valid, output lat_deg, output lon_deg, input ready);
  modport sink   (input valid, input lat_deg, input lon_deg, output ready);
endinterface

>>> design/llu_out_if.sv
// Output channel: one unit vector and its range error flag.
`timescale 1ns / 1ps
interface llu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [llu_pkg::OUT_W-1:0] x_comp;
  logic signed [llu_pkg::OUT_W-1:0] y_comp;
  logic signed [llu_pkg::OUT_W-1:0] z_comp;
  logic                              range_error;

  modport source (output valid, output x_comp, output y_comp, output z_comp,
                  output range_error, input ready);
  modport sink   (input valid, input x_comp, input y_comp, input z_comp,
                  input range_error, output ready);
endinterface

>>> design/llu_prep.sv
// Front end: range check, longitude fold and degree to radian scaling.
`timescale 1ns / 1ps
module llu_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [llu_pkg::LAT_W-1:0] lat_i,
  input  logic signed [llu_pkg::LON_W-1:0] lon_i,
  output logic                              valid_o,
  output llu_pkg::cell_bus_t                bus_o
);
  import llu_pkg::*;

  localparam logic signed [DRAD_LO_W:0] DRAD_LO_S = {1'b0, DEG2RAD[DRAD_LO_W-1:0]};
  localparam logic signed [DRAD_HI_W:0] DRAD_HI_S = {1'b0, DEG2RAD[DRAD_W-1:DRAD_LO_W]};

  // Stage A: checked and folded angles.
  logic                    a_valid_q;
  logic signed [ANG_W-1:0] a_lat_q, a_lon_q;
  logic                    a_neg_q, a_err_q;
  logic signed [ANG_W-1:0] lat_ext, lon_fold;
  logic                    neg_d, err_d;

  // Stage B: partial products of the radian scaling.
  logic                    b_valid_q;
  logic signed [PLO_W-1:0] b_lat_lo_q, b_lon_lo_q;
  logic signed [PHI_W-1:0] b_lat_hi_q, b_lon_hi_q;
  logic                    b_neg_q, b_err_q;

  // Stage C: angles in radians with the start vector.
  logic      c_valid_q;
  cell_bus_t c_bus_q;
  cell_bus_t c_bus_d;

  always_comb begin
    lat_ext  = ANG_W'(lat_i);
    err_d    = !(lat_ext >= -DEG90 && lat_ext <= DEG90 && lon_i > -DEG180 && lon_i <= DEG180);
    neg_d    = 1'b0;
    lon_fold = lon_i;
    if (lon_i > DEG90) begin
      lon_fold = lon_i - DEG180;
      neg_d    = 1'b1;
    end else if (lon_i < -DEG90) begin
      lon_fold = lon_i + DEG180;
      neg_d    = 1'b1;
    end
  end

  always_comb begin
    c_bus_d.err   = b_err_q;
    c_bus_d.neg   = b_neg_q;
    c_bus_d.lat.x = GAIN_Q40;
    c_bus_d.lat.y = '0;
    c_bus_d.lat.z = {b_lat_hi_q[Z_W-DRAD_LO_W-1:0], {DRAD_LO_W{1'b0}}}
                  + {{(Z_W-PLO_W){b_lat_lo_q[PLO_W-1]}}, b_lat_lo_q};
    c_bus_d.lon.x = GAIN_Q40;
    c_bus_d.lon.y = '0;
    c_bus_d.lon.z = {b_lon_hi_q[Z_W-DRAD_LO_W-1:0], {DRAD_LO_W{1'b0}}}
                  + {{(Z_W-PLO_W){b_lon_lo_q[PLO_W-1]}}, b_lon_lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_lat_q    <= lat_ext;
      a_lon_q    <= lon_fold;
      a_neg_q    <= neg_d;
      a_err_q    <= err_d;
      b_lat_lo_q <= a_lat_q * DRAD_LO_S;
      b_lat_hi_q <= a_lat_q * DRAD_HI_S;
      b_lon_lo_q <= a_lon_q * DRAD_LO_S;
      b_lon_hi_q <= a_lon_q * DRAD_HI_S;
      b_neg_q    <= a_neg_q;
      b_err_q    <= a_err_q;
      c_bus_q    <= c_bus_d;
    end
  end

  assign valid_o = c_valid_q;
  assign bus_o   = c_bus_q;

endmodule

>>> design/llu_cordic_cell.sv
// One CORDIC rotation step for the latitude and longitude lanes.
`timescale 1ns / 1ps
module llu_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  llu_pkg::cell_bus_t bus_i,
  output logic               valid_o,
  output llu_pkg::cell_bus_t bus_o
);
  import llu_pkg::*;

  localparam logic [Z_W-1:0] Atan = atan_q60(Idx);

  logic      valid_q;
  cell_bus_t bus_q;
  cell_bus_t bus_d;

  // Rotate toward zero remaining angle; a non-negative angle counts as positive.
  function automatic lane_t rotate(lane_t l);
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    lane_t                  r;
    xs = $signed(l.x) >>> Idx;
    ys = $signed(l.y) >>> Idx;
    if (!l.z[Z_W-1]) begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.z = l.z - Atan;
    end else begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.z = l.z + Atan;
    end
    return r;
  endfunction

  always_comb begin
    bus_d     = bus_i;
    bus_d.lat = rotate(bus_i.lat);
    bus_d.lon = rotate(bus_i.lon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign valid_o = valid_q;
  assign bus_o   = bus_q;

endmodule

>>> design/llu_post.sv
// Back end: rounding to Q30, quadrant sign, the two products and the output register.
`timescale 1ns / 1ps
module llu_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  llu_pkg::cell_bus_t bus_i,
  output logic               valid_o,
  output llu_pkg::result_t   res_o
);
  import llu_pkg::*;

  localparam int unsigned RW = XY_W + 1;
  localparam int unsigned PW = 2 * OUT_W;

  // Q40 to Q30 with rounding and clamping to the unit range.
  function automatic logic signed [OUT_W-1:0] round_q40(logic [XY_W-1:0] v);
    logic signed [RW-1:0] t;
    t = $signed({v[XY_W-1], v}) + RW'(512);
    t = t >>> 10;
    if (t > ONE_Q30) begin
      return ONE_Q30;
    end else if (t < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return t[OUT_W-1:0];
  endfunction

  // Q60 product to Q30 with rounding and clamping.
  function automatic logic signed [OUT_W-1:0] round_q60(logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(64'd536870912);
    t = t >>> 30;
    if (t > ONE_Q30) begin
      return ONE_Q30;
    end else if (t < -ONE_Q30) begin
      return -ONE_Q30;
    end
    return t[OUT_W-1:0];
  endfunction

  logic                    p1_valid_q, p2_valid_q, o_valid_q;
  logic signed [OUT_W-1:0] cl_q, sl_q, co_q, so_q;
  logic signed [OUT_W-1:0] co_d, so_d, co_r, so_r;
  logic                    p1_err_q, p2_err_q;
  logic signed [PW-1:0]    px_q, py_q;
  logic signed [OUT_W-1:0] p2_z_q;
  result_t                 res_q;
  result_t                 res_d;

  always_comb begin
    co_r = round_q40(bus_i.lon.x);
    so_r = round_q40(bus_i.lon.y);
    co_d = bus_i.neg ? -co_r : co_r;
    so_d = bus_i.neg ? -so_r : so_r;
  end

  // An invalid point leaves the vector at zero.
  always_comb begin
    res_d.err = p2_err_q;
    res_d.x   = p2_err_q ? '0 : round_q60(px_q);
    res_d.y   = p2_err_q ? '0 : round_q60(py_q);
    res_d.z   = p2_err_q ? '0 : p2_z_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else if (en_i) begin
      p1_valid_q <= valid_i;
      p2_valid_q <= p1_valid_q;
      o_valid_q  <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cl_q     <= round_q40(bus_i.lat.x);
      sl_q     <= round_q40(bus_i.lat.y);
      co_q     <= co_d;
      so_q     <= so_d;
      p1_err_q <= bus_i.err;
      px_q     <= cl_q * co_q;
      py_q     <= cl_q * so_q;
      p2_z_q   <= sl_q;
      p2_err_q <= p1_err_q;
      res_q    <= res_d;
    end
  end

  assign valid_o = o_valid_q;
  assign res_o   = res_q;

endmodule

>>> design/latlon_to_unit_vector.sv
// Latitude/longitude to unit vector converter built as a chain of CORDIC cells.
// Path of a transaction: three front-end stages, one cell per rotation step, and
// three back-end stages ending in the output register.
// Throughput: one transaction per cycle; the whole chain advances together and holds
// only while the output register is full and not taken. Reset clears all valid bits.
`timescale 1ns / 1ps
module latlon_to_unit_vector #(
  parameter int unsigned CordicSteps = llu_pkg::CORDIC_STEPS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  llu_in_if.sink    in_i,
  llu_out_if.source out_o
);
  import llu_pkg::*;

  // The pipeline is one chain with a common enable. It moves whenever the output
  // register is empty or its transaction is being taken this cycle, so a new point
  // can enter in the same cycle as a finished vector leaves.
  logic      en;
  logic      res_valid;
  result_t   res;

  // Stage k of the chain is the input of CORDIC cell k; the last entry feeds the back end.
  logic      chain_valid [CordicSteps+1];
  cell_bus_t chain_bus   [CordicSteps+1];

  assign en         = !res_valid || out_o.ready;
  assign in_i.ready = en;

  // Front end: validity check of the point, longitude folded into [-90, 90] with a
  // sign flag, and the scaling from degrees to radians as two partial products.
  llu_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .lat_i   (in_i.lat_deg),
    .lon_i   (in_i.lon_deg),
    .valid_o (chain_valid[0]),
    .bus_o   (chain_bus[0])
  );

  // One cell per rotation step. Each cell rotates both the latitude and the
  // longitude vector by its own fixed arctangent and hands them to the next cell.
  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    llu_cordic_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .bus_i   (chain_bus[g]),
      .valid_o (chain_valid[g+1]),
      .bus_o   (chain_bus[g+1])
    );
  end

  // Back end: sine and cosine rounded to Q30, the fold sign applied, the two
  // products with cos(lat), and the output register with the error override.
  llu_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[CordicSteps]),
    .bus_i   (chain_bus[CordicSteps]),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_o.valid       = res_valid;
  assign out_o.x_comp      = res.x;
  assign out_o.y_comp      = res.y;
  assign out_o.z_comp      = res.z;
  assign out_o.range_error = res.err;

endmodule
